[rtl/touch_report_decoder_unit_macros.svh]
// Assertion macros for the touch report decoder checker.
`ifndef TOUCH_REPORT_DECODER_UNIT_MACROS_SVH
`define TOUCH_REPORT_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/trd_pkg.sv]
package trd_pkg;

   localparam int BYTE_W        = 8;
   localparam int COORD_W       = 16;
   localparam int ORIENT_W      = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int POINT_INDEX_W = 3;
   localparam int COUNT_W       = 4;
   localparam int RAW_W         = 32;
   localparam int POLL_W        = 8;
   localparam int POLL_MOD_W    = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENTATION  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_HEIGHT = 2'd2;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd800;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [COORD_W-1:0] NO_TOUCH     = 16'hFFFF;

   // status byte codes
   localparam logic [BYTE_W-1:0]  STATUS_READY = 8'h80;
   localparam logic [BYTE_W-1:0]  REL_MASK     = 8'h8F;
   localparam logic [BYTE_W-1:0]  KEEP_MASK    = 8'hE0;
   localparam logic [BYTE_W-1:0]  CAUGHT_BITS  = 8'hC0;
   localparam int                 PRESSED_BIT  = 7;
   localparam logic [COUNT_W-1:0] CLEAR_LIMIT  = 4'd6;

   // poll counter
   localparam logic [POLL_W-1:0]     POLL_PERIOD     = 8'd10;
   localparam logic [POLL_MOD_W-1:0] POLL_MOD_TOP    = 4'd9;
   localparam logic [POLL_W-1:0]     POLL_WRAP_LIMIT = 8'd240;
   localparam logic [POLL_W-1:0]     POLL_RESTART    = 8'd10;

   typedef enum logic [ORIENT_W-1:0] {
      ORIENT_NATIVE,
      ORIENT_ROTATE,
      ORIENT_FLIP,
      ORIENT_ROTATE_BACK
   } orient_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SCAN,
      OP_BYTE,
      OP_RD_STAT,
      OP_CAP_STAT,
      OP_RD_ID,
      OP_CAP_ID,
      OP_BACKUP,
      OP_FETCH,
      OP_MAP,
      OP_CHECK,
      OP_RELEASE,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] sub;    // byte within a coordinate pair
      logic       issue;  // launch a frame store read
      logic       cap;    // shift read byte into the raw pair
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a result
      logic frame_ok;  // count in read status byte is in range
      logic id_last;   // current track id is the last one
      logic slot_hit;  // current slot is flagged in the mask
   } dp_sts_type;

   typedef struct packed {
      logic [COORD_W-1:0]       point_y;
      logic [COORD_W-1:0]       point_x;
      logic [POINT_INDEX_W-1:0] point_index;
      logic [BYTE_W-1:0]        status_byte;
      logic                     touch_valid;
      logic                     clear_request;
      logic                     poll_request;
   } rsp_fields_type;

   localparam int RSP_ITEM_W  = $bits(rsp_fields_type);
   localparam int RSP_TDATA_W = ((RSP_ITEM_W + 7) / 8) * 8;

endpackage

[rtl/trd_ctrl.sv]
module trd_ctrl #(
   parameter int  MAX_POINTS = 5,
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   req_tready,
   input  trd_pkg::dp_sts_type    sts,
   output trd_pkg::dp_cmd_type    cmd,
   output logic [IDX_W-1:0]       idx
);
   import trd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_STAT,
      S_CAP_STAT,
      S_RD_ID,
      S_CAP_ID,
      S_BACKUP,
      S_SEL,
      S_FETCH,
      S_MAP,
      S_CHECK,
      S_RELEASE,
      S_EMIT
   } state_type;

   localparam logic [IDX_W-1:0] LAST_SLOT   = IDX_W'(MAX_POINTS - 1);
   localparam logic [2:0]       FETCH_BEATS = 3'd4;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       beat_ff, beat_in;
   logic             last_slot;

   assign last_slot = (idx_ff == LAST_SLOT);
   assign idx       = idx_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      beat_in    = beat_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.sub    = beat_ff[1:0];
      cmd.issue  = 1'b0;
      cmd.cap    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = sts.out_free;
            if (req_tvalid && sts.out_free) begin
               if (!req_tuser) begin
                  cmd.op = OP_SCAN;
               end else begin
                  cmd.op = OP_BYTE;
                  if (req_tlast) begin
                     state_in = S_RD_STAT;
                  end
               end
            end
         end
         S_RD_STAT: begin
            cmd.op   = OP_RD_STAT;
            state_in = S_CAP_STAT;
         end
         S_CAP_STAT: begin
            cmd.op   = OP_CAP_STAT;
            idx_in   = '0;
            state_in = sts.frame_ok ? S_RD_ID : S_RELEASE;
         end
         S_RD_ID: begin
            cmd.op   = OP_RD_ID;
            state_in = S_CAP_ID;
         end
         S_CAP_ID: begin
            cmd.op = OP_CAP_ID;
            if (sts.id_last) begin
               idx_in   = '0;
               state_in = S_BACKUP;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RD_ID;
            end
         end
         S_BACKUP: begin
            cmd.op   = OP_BACKUP;
            state_in = S_SEL;
         end
         S_SEL: begin
            if (sts.slot_hit) begin
               beat_in  = '0;
               state_in = S_FETCH;
            end else if (last_slot) begin
               state_in = S_CHECK;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_FETCH: begin
            cmd.op    = OP_FETCH;
            cmd.issue = (beat_ff < FETCH_BEATS);
            cmd.cap   = (beat_ff != 3'd0);
            if (beat_ff == FETCH_BEATS) begin
               state_in = S_MAP;
            end else begin
               beat_in = beat_ff + 3'd1;
            end
         end
         S_MAP: begin
            cmd.op = OP_MAP;
            if (last_slot) begin
               state_in = S_CHECK;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SEL;
            end
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_RELEASE;
         end
         S_RELEASE: begin
            cmd.op   = OP_RELEASE;
            idx_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.op = OP_EMIT;
               if (last_slot) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         beat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         beat_ff  <= beat_in;
      end
   end

endmodule

[rtl/trd_datapath.sv]
module trd_datapath #(
   parameter int  MAX_POINTS  = 5,
   parameter int  FRAME_BYTES = 42,
   localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int ADDR_W      = $clog2(FRAME_BYTES),
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [trd_pkg::BYTE_W-1:0]            in_byte,
   input  logic                                  in_last,
   input  logic                                  csr_valid,
   input  logic [trd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]        csr_data,
   input  trd_pkg::dp_cmd_type                   cmd,
   input  logic [IDX_W-1:0]                      idx,
   output trd_pkg::dp_sts_type                   sts,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [trd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);
   import trd_pkg::*;

   localparam int               ONE_SLOT    = 1 % MAX_POINTS;
   localparam int               BACKUP_SLOT = MAX_POINTS - 1;
   localparam logic [IDX_W-1:0] LAST_SLOT   = IDX_W'(MAX_POINTS - 1);

   // configuration
   orient_type           orient_ff;
   logic [COORD_W-1:0]   width_ff;
   logic [COORD_W-1:0]   height_ff;

   // frame store
   logic [BYTE_W-1:0]    frame_mem [FRAME_BYTES];
   logic [CNT_W-1:0]     bcnt_ff;
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    slot_base;

   // decode state
   logic [BYTE_W-1:0]     s_ff;
   logic                  forced_ff;
   logic [MAX_POINTS-1:0] mask_ff;
   logic [BYTE_W-1:0]     status_ff;
   logic [BYTE_W-1:0]     saved_ff;
   logic [RAW_W-1:0]      raw_ff;
   logic [COORD_W-1:0]    pt_x_ff [MAX_POINTS];
   logic [COORD_W-1:0]    pt_y_ff [MAX_POINTS];
   logic [POLL_W-1:0]     pc_ff;
   logic [POLL_MOD_W-1:0] mod_ff;

   // output register
   logic                  rsp_vld_ff;
   rsp_fields_type        rsp_item_ff;
   logic                  rsp_last_ff;

   logic [MAX_POINTS-1:0] slot_bits;
   logic [COORD_W-1:0]    rx, ry, mx, my;
   logic                  bad_first, multi, rollback, release_hit;
   logic [BYTE_W-1:0]     eff_s;
   logic [POLL_W-1:0]     pc_inc;
   logic [POLL_MOD_W-1:0] mod_inc;
   logic                  poll, wrap, id_ok;
   rsp_fields_type        scan_item, emit_item;

   function automatic logic count_ok(input logic [COUNT_W-1:0] n);
      return (n != '0) && (n <= COUNT_W'(MAX_POINTS));
   endfunction

   // ---- read address ----
   assign slot_base = ADDR_W'(idx) << 3;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.op)
         OP_RD_STAT: begin
            rd_en = 1'b1;
         end
         OP_RD_ID: begin
            rd_en   = 1'b1;
            rd_addr = slot_base + ADDR_W'(1);
         end
         OP_FETCH: begin
            rd_en   = cmd.issue;
            rd_addr = slot_base + ADDR_W'(2) + ADDR_W'(cmd.sub);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_BYTE && bcnt_ff < CNT_W'(FRAME_BYTES)) begin
         frame_mem[bcnt_ff[ADDR_W-1:0]] <= in_byte;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   // ---- status to controller ----
   assign slot_bits    = status_ff[MAX_POINTS-1:0];
   assign sts.out_free = !rsp_vld_ff || rsp_tready;
   assign sts.frame_ok = count_ok(rd_data_ff[COUNT_W-1:0]);
   assign sts.id_last  = (COUNT_W'(idx) + COUNT_W'(1)) == s_ff[COUNT_W-1:0];
   assign sts.slot_hit = slot_bits[idx];

   // ---- coordinate mapping ----
   assign rx = raw_ff[COORD_W-1:0];
   assign ry = raw_ff[RAW_W-1:COORD_W];

   always_comb begin
      case (orient_ff)
         ORIENT_NATIVE: begin
            mx = rx;
            my = ry;
         end
         ORIENT_ROTATE: begin
            mx = ry;
            my = height_ff - rx;
         end
         ORIENT_FLIP: begin
            mx = width_ff - rx;
            my = height_ff - ry;
         end
         ORIENT_ROTATE_BACK: begin
            mx = width_ff - ry;
            my = rx;
         end
         default: begin
            mx = rx;
            my = ry;
         end
      endcase
   end

   // ---- first point check and release ----
   assign id_ok       = rd_data_ff < BYTE_W'(MAX_POINTS);
   assign bad_first   = (pt_x_ff[0] > width_ff) || (pt_y_ff[0] > height_ff);
   assign multi       = s_ff[COUNT_W-1:0] > COUNT_W'(1);
   assign rollback    = bad_first && !multi;
   assign eff_s       = forced_ff ? STATUS_READY : s_ff;
   assign release_hit = (eff_s & REL_MASK) == STATUS_READY;

   // ---- poll counter; mod_ff tracks pc_ff modulo ten ----
   assign pc_inc  = pc_ff + POLL_W'(1);
   assign mod_inc = (mod_ff == POLL_MOD_TOP) ? '0 : mod_ff + POLL_MOD_W'(1);
   assign poll    = (mod_inc == '0) || (pc_inc < POLL_PERIOD);
   assign wrap    = pc_inc > POLL_WRAP_LIMIT;

   // ---- result items ----
   always_comb begin
      scan_item              = '0;
      scan_item.poll_request = poll;
      emit_item.poll_request  = 1'b0;
      emit_item.clear_request = s_ff[PRESSED_BIT] && (s_ff[COUNT_W-1:0] < CLEAR_LIMIT);
      emit_item.touch_valid   = count_ok(s_ff[COUNT_W-1:0]);
      emit_item.status_byte   = status_ff;
      emit_item.point_index   = POINT_INDEX_W'(idx);
      emit_item.point_x       = pt_x_ff[idx];
      emit_item.point_y       = pt_y_ff[idx];
   end

   // ---- registers with reset ----
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff  <= ORIENT_NATIVE;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         bcnt_ff    <= '0;
         status_ff  <= '0;
         pc_ff      <= '0;
         mod_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < MAX_POINTS; i++) begin
            pt_x_ff[i] <= '0;
            pt_y_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ORIENTATION:  orient_ff <= orient_type'(csr_data[ORIENT_W-1:0]);
               CSR_PANEL_WIDTH:  width_ff  <= csr_data;
               CSR_PANEL_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end

         if (cmd.op == OP_SCAN || cmd.op == OP_EMIT) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end

         case (cmd.op)
            OP_SCAN: begin
               pc_ff  <= wrap ? POLL_RESTART : pc_inc;
               mod_ff <= wrap ? '0 : mod_inc;
            end
            OP_BYTE: begin
               if (in_last) begin
                  bcnt_ff <= '0;
               end else if (bcnt_ff < CNT_W'(FRAME_BYTES)) begin
                  bcnt_ff <= bcnt_ff + CNT_W'(1);
               end
            end
            OP_BACKUP: begin
               status_ff            <= CAUGHT_BITS | BYTE_W'(mask_ff);
               pt_x_ff[BACKUP_SLOT] <= pt_x_ff[0];
               pt_y_ff[BACKUP_SLOT] <= pt_y_ff[0];
            end
            OP_MAP: begin
               pt_x_ff[idx] <= mx;
               pt_y_ff[idx] <= my;
            end
            OP_CHECK: begin
               if (rollback) begin
                  pt_x_ff[0] <= pt_x_ff[BACKUP_SLOT];
                  pt_y_ff[0] <= pt_y_ff[BACKUP_SLOT];
                  status_ff  <= saved_ff;
               end else begin
                  if (bad_first) begin
                     pt_x_ff[0] <= pt_x_ff[ONE_SLOT];
                     pt_y_ff[0] <= pt_y_ff[ONE_SLOT];
                  end
                  pc_ff  <= '0;
                  mod_ff <= '0;
               end
            end
            OP_RELEASE: begin
               if (release_hit) begin
                  if (status_ff[PRESSED_BIT]) begin
                     status_ff[PRESSED_BIT] <= 1'b0;
                  end else begin
                     pt_x_ff[0] <= NO_TOUCH;
                     pt_y_ff[0] <= NO_TOUCH;
                     status_ff  <= status_ff & KEEP_MASK;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SCAN: begin
            rsp_item_ff <= scan_item;
            rsp_last_ff <= 1'b1;
         end
         OP_EMIT: begin
            rsp_item_ff <= emit_item;
            rsp_last_ff <= (idx == LAST_SLOT);
         end
         OP_CAP_STAT: begin
            s_ff      <= rd_data_ff;
            forced_ff <= 1'b0;
            mask_ff   <= '0;
         end
         OP_CAP_ID: begin
            if (id_ok) begin
               mask_ff[rd_data_ff[IDX_W-1:0]] <= 1'b1;
            end
         end
         OP_BACKUP: begin
            saved_ff <= status_ff;
         end
         OP_FETCH: begin
            if (cmd.cap) begin
               raw_ff <= {rd_data_ff, raw_ff[RAW_W-1:BYTE_W]};
            end
         end
         OP_CHECK: begin
            if (rollback) begin
               forced_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_ITEM_W){1'b0}}, rsp_item_ff};

endmodule

[rtl/touch_report_decoder_unit.sv]
// Touch point report decoder. Each req transaction is either a scan event
// (tuser 0) or one byte of a report frame (tuser 1, tlast on the final byte).
// A scan event returns one result in the next cycle, whose poll_request says
// whether to read a frame now: every call while the poll counter is below
// ten, then every tenth. Report bytes are taken one per cycle, while the
// output register is free, into a frame store of FRAME_BYTES entries; extra
// bytes are dropped. The final byte starts a decode run by the sequencer,
// which holds off req transactions until the run has delivered its
// MAX_POINTS results. The run reads the status byte; if its count is in
// range, it reads each track id, makes the backup copy, fetches and maps
// each flagged slot, skips each empty one and does the first point check,
// then releases and emits one result per cycle while rsp is ready. The frame
// store is read one byte at a time. A stalled result sits in the output
// register and blocks the next one. Configuration writes are always accepted
// (csr_ready is tied high) and must only be issued while the block is idle.
// The frame store has no reset and holds old bytes until overwritten.
module touch_report_decoder_unit #(
   parameter int MAX_POINTS  = 5,
   parameter int FRAME_BYTES = 42
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [trd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                              req_tuser,   // [0] cmd
   input  logic                              req_tlast,   // last_byte
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] poll_request, [1] clear_request, [2] touch_valid, [10:3] status_byte,
   // [13:11] point_index, [29:14] point_x, [45:30] point_y, [47:46] zero
   output logic [trd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,   // last_point
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import trd_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic [IDX_W-1:0] idx;

   assign csr_ready = 1'b1;

   // sequencer: accepts transactions and steps the decode run
   trd_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .idx        (idx)
   );

   // frame store, point registers, poll counter and output register
   trd_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .idx        (idx),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/trd_checker.sv]
`include "touch_report_decoder_unit_macros.svh"

module trd_checker #(
   parameter int MAX_POINTS = 5
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [trd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);
   import trd_pkg::*;

   rsp_fields_type rsp_item;
   logic           scan_take;
   logic           frame_end_take;

   assign rsp_item       = rsp_tdata[RSP_ITEM_W-1:0];
   assign scan_take      = req_tvalid && req_tready && !req_tuser;
   assign frame_end_take = req_tvalid && req_tready && req_tuser && req_tlast;

   // stalled result holds
   `TRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // scan transaction answers with a single result next cycle
   `TRD_ASSERT_NEXT(a_scan_answer, clock, reset, scan_take, rsp_tvalid && rsp_tlast)

   // no input taken while a decode run is under way
   `TRD_ASSERT_NEXT(a_decode_busy, clock, reset, frame_end_take, !req_tready)

   // point index stays within the stored slots
   `TRD_ASSERT_SAME(a_index_range, clock, reset, rsp_tvalid, rsp_item.point_index <= POINT_INDEX_W'(MAX_POINTS - 1))

   // a poll request only comes on a lone scan result
   `TRD_ASSERT_SAME(a_poll_alone, clock, reset, rsp_tvalid && rsp_item.poll_request, rsp_tlast && (rsp_item.point_index == '0))

endmodule

bind touch_report_decoder_unit trd_checker #(
   .MAX_POINTS (MAX_POINTS)
) u_trd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
